// ===== hw/rtl/bfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bfc_pkg;

  // Conversion selector
  typedef enum logic [1:0] {
    OP_INT_TO_BF = 2'd0,
    OP_BF_TO_INT = 2'd1,
    OP_FP_TO_BF  = 2'd2,
    OP_BF_TO_FP  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] operand;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        nan_seen;
  } out_word_t;

  localparam logic [7:0]  BIAS       = 8'd127;
  localparam logic [7:0]  EXP_MAX    = 8'hFF;
  localparam logic [15:0] BF_NAN     = 16'h7F81;
  localparam logic [15:0] BF_POS_INF = 16'h7F80;
  localparam logic [15:0] BF_NEG_INF = 16'hFF80;
  localparam logic [31:0] I32_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_MIN    = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== hw/rtl/bfc_int_to_bf.sv =====
`timescale 1ns / 1ps
`default_nettype none

// int32 to bf16, round to nearest even
module bfc_int_to_bf (
  input  logic [31:0] operand,
  output logic [15:0] result
);
  import bfc_pkg::*;

  logic        sign;
  logic [31:0] mag;
  logic [31:0] norm;
  logic [4:0]  lead;
  logic        guard;
  logic        sticky;
  logic [8:0]  keep_rnd;
  logic [7:0]  expo;
  logic [6:0]  frac;

  always_comb begin
    sign = operand[31];
    mag  = sign ? (32'd0 - operand) : operand;
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        lead = 5'(i);
      end
    end
    // leading one to bit 31
    norm     = mag << (5'd31 - lead);
    guard    = norm[23];
    sticky   = |norm[22:0];
    keep_rnd = {1'b0, norm[31:24]} + 9'(guard && (sticky || norm[24]));
    expo     = 8'({3'd0, lead}) + BIAS + 8'(keep_rnd[8]);
    frac     = keep_rnd[8] ? 7'd0 : keep_rnd[6:0];
    result   = (mag == 32'd0) ? 16'd0 : {sign, expo, frac};
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfc_bf_to_int.sv =====
`timescale 1ns / 1ps
`default_nettype none

// bf16 to int32, round to nearest even, saturating
module bfc_bf_to_int (
  input  logic [15:0] operand,
  output logic [31:0] result,
  output logic        nan
);
  import bfc_pkg::*;

  localparam logic [7:0] EXP_SAT  = BIAS + 8'd31;
  localparam logic [7:0] EXP_INTG = BIAS + 8'd7;

  logic        sign;
  logic [7:0]  expo;
  logic [6:0]  frac;
  logic [7:0]  m;
  logic [4:0]  lsh;
  logic [7:0]  rsh;
  logic [15:0] ext;
  logic [8:0]  q_rnd;
  logic [31:0] mag;
  logic [31:0] sat;

  always_comb begin
    sign  = operand[15];
    expo  = operand[14:7];
    frac  = operand[6:0];
    m     = {1'b1, frac};
    lsh   = 5'(expo - EXP_INTG);
    rsh   = EXP_INTG - expo;
    ext   = {m, 8'd0} >> rsh[3:0];
    q_rnd = {1'b0, ext[15:8]} + 9'(ext[7] && ((|ext[6:0]) || ext[8]));
    if (expo >= EXP_INTG) begin
      mag = {24'd0, m} << lsh;
    end else if (rsh > 8'd8) begin
      mag = 32'd0;
    end else begin
      mag = {23'd0, q_rnd};
    end
    sat = sign ? I32_MIN : I32_MAX;
    nan = 1'b0;
    if (expo == 8'd0) begin
      result = 32'd0;
    end else if (expo == EXP_MAX) begin
      nan    = (frac != 7'd0);
      result = nan ? I32_MIN : sat;
    end else if (expo >= EXP_SAT) begin
      result = sat;
    end else begin
      result = sign ? (32'd0 - mag) : mag;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfc_fp_to_bf.sv =====
`timescale 1ns / 1ps
`default_nettype none

// fp32 to bf16, round to nearest even; carry into exponent gives inf
module bfc_fp_to_bf (
  input  logic [31:0] operand,
  output logic [15:0] result
);
  import bfc_pkg::*;

  logic [7:0]  expo;
  logic [15:0] upper;
  logic [15:0] lower;
  logic        rnd;

  always_comb begin
    expo  = operand[30:23];
    upper = operand[31:16];
    lower = operand[15:0];
    rnd   = (lower > 16'h8000) || ((lower == 16'h8000) && upper[0]);
    if (expo == EXP_MAX) begin
      if (operand[22:0] != 23'd0) begin
        result = BF_NAN;
      end else begin
        result = operand[31] ? BF_NEG_INF : BF_POS_INF;
      end
    end else begin
      result = upper + 16'(rnd);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bf16_format_converter.sv =====
// bf16_format_converter: bfloat16 format converter.
// Input channel in_*: one word carries op and a 32-bit operand. op picks
//   int32->bf16, bf16->int32, fp32->bf16 or bf16->fp32; bf16 sources sit in
//   operand[15:0]. Rounding is to nearest, ties to even.
// Output channel out_*: one word per input word, result_bits plus nan_seen
//   (set only for a NaN in bf16->int32). bf16 results are zero-extended.
// A word is taken on a rising edge with valid high and stall low.
// After acceptance a word passes the input register, then the result
//   register, before out_valid rises with its result.
//   Throughput: one word per cycle while out_stall is low; no state links words.
// Stall: out_stall holds the result register. An empty input register still
//   fills behind it, so at most one more word is taken before in_stall rises.
// Reset (rst_n low, synchronous): both stages empty, out_valid low.
`timescale 1ns / 1ps
`default_nettype none

module bf16_format_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bfc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bfc_pkg::out_word_t out_data
);
  import bfc_pkg::*;

  // input register
  logic      s1_valid_r;
  in_word_t  s1_data_r;
  // result register
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t out_data_nxt;

  logic        adv_out;
  logic        adv_in;
  logic [15:0] i2b_res;
  logic [31:0] b2i_res;
  logic        b2i_nan;
  logic [15:0] f2b_res;

  // result stage moves when empty or taken; input stage moves into it
  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_in   = !s1_valid_r || adv_out;
  assign in_stall = !adv_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_in) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  bfc_int_to_bf u_int_to_bf (
    .operand (s1_data_r.operand),
    .result  (i2b_res)
  );

  bfc_bf_to_int u_bf_to_int (
    .operand (s1_data_r.operand[15:0]),
    .result  (b2i_res),
    .nan     (b2i_nan)
  );

  bfc_fp_to_bf u_fp_to_bf (
    .operand (s1_data_r.operand),
    .result  (f2b_res)
  );

  always_comb begin
    out_data_nxt.nan_seen = 1'b0;
    case (s1_data_r.op)
      OP_INT_TO_BF: begin
        out_data_nxt.result_bits = {16'd0, i2b_res};
      end
      OP_BF_TO_INT: begin
        out_data_nxt.result_bits = b2i_res;
        out_data_nxt.nan_seen    = b2i_nan;
      end
      OP_FP_TO_BF: begin
        out_data_nxt.result_bits = {16'd0, f2b_res};
      end
      default: begin
        // bf16 -> fp32 is exact: low half zero
        out_data_nxt.result_bits = {s1_data_r.operand[15:0], 16'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for bf16_format_converter.
// A directed table comes first, then ~750 random words; fixed rows are
// scored against typed-in words, all else against the behavioural model below.
// Both handshakes see random idle bursts but for a quiet stretch mid-run and a quiet tail.
module testbench;
  import bfc_pkg::*;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;

  // Converted word still owed by the block, kept with its source for messages
  typedef struct packed {
    in_word_t  src;
    out_word_t want;
  } conversion_t;

  conversion_t owed_words[$];
  int          mismatch_count = 0;
  int          stall_left     = 0;
  bit          in_idle_on     = 1'b1;
  bit          out_idle_on    = 1'b1;

  // Directed table: fixed = 1 means the expected word is typed in here,
  // otherwise it comes from the model below.
  typedef struct packed {
    op_t         op;
    logic [31:0] operand;
    logic        fixed;
    logic [31:0] want_bits;
    logic        want_nan;
  } directed_row_t;

  directed_row_t directed_rows [25] = '{
    // int32 -> bf16: zero, most negative, largest positive, small, tie
    '{OP_INT_TO_BF, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_INT_TO_BF, 32'h8000_0000, 1'b1, 32'h0000_CF00, 1'b0},
    '{OP_INT_TO_BF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_INT_TO_BF, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{OP_INT_TO_BF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_INT_TO_BF, 32'h0000_0181, 1'b0, 32'h0, 1'b0},
    // bf16 -> int32: upper bits ignored, zero/denormal, halves, saturation, NaN
    '{OP_BF_TO_INT, 32'hFFFF_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_BF_TO_INT, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_BF_TO_INT, 32'h0000_3F00, 1'b0, 32'h0, 1'b0},
    '{OP_BF_TO_INT, 32'h0000_3F01, 1'b0, 32'h0, 1'b0},
    '{OP_BF_TO_INT, 32'hA5A5_BF01, 1'b0, 32'h0, 1'b0},
    '{OP_BF_TO_INT, 32'h0000_7F80, 1'b1, I32_MAX, 1'b0},
    '{OP_BF_TO_INT, 32'h0000_FF80, 1'b1, I32_MIN, 1'b0},
    '{OP_BF_TO_INT, 32'h0000_4F00, 1'b1, I32_MAX, 1'b0},
    '{OP_BF_TO_INT, 32'h0000_CF00, 1'b1, I32_MIN, 1'b0},
    '{OP_BF_TO_INT, 32'h0000_7FC0, 1'b1, I32_MIN, 1'b1},
    '{OP_BF_TO_INT, 32'hFFFF_FFFF, 1'b1, I32_MIN, 1'b1},
    // fp32 -> bf16: NaN of either sign, infinities, rounding overflow, tie
    '{OP_FP_TO_BF, 32'h7FC0_0000, 1'b1, {16'h0, BF_NAN}, 1'b0},
    '{OP_FP_TO_BF, 32'hFF80_0001, 1'b1, {16'h0, BF_NAN}, 1'b0},
    '{OP_FP_TO_BF, 32'h7F80_0000, 1'b1, {16'h0, BF_POS_INF}, 1'b0},
    '{OP_FP_TO_BF, 32'hFF80_0000, 1'b1, {16'h0, BF_NEG_INF}, 1'b0},
    '{OP_FP_TO_BF, 32'h7F7F_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_FP_TO_BF, 32'h3F80_8000, 1'b0, 32'h0, 1'b0},
    // bf16 -> fp32: all ones, upper bits ignored
    '{OP_BF_TO_FP, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_BF_TO_FP, 32'h1234_0000, 1'b0, 32'h0, 1'b0}
  };

  bf16_format_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Converter model
  // ---------------------------------------------------------------------

  // int32 -> bf16, nearest-even on the bits below the 8-bit significand
  function automatic logic [15:0] int_to_bf16(logic [31:0] x);
    logic        sign;
    logic [31:0] mag, keep, rem, half;
    logic [7:0]  expo;
    logic [6:0]  frac;
    int          lead, drop;
    sign = x[31];
    mag  = sign ? (~x + 32'd1) : x;
    if (mag == 32'd0) return 16'h0000;
    lead = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) lead = i;
    expo = 8'(lead) + BIAS;
    if (lead <= 7) begin
      frac = 7'(mag << (7 - lead));
    end else begin
      drop = lead - 7;
      keep = mag >> drop;
      rem  = mag & ((32'd1 << drop) - 32'd1);
      half = 32'd1 << (drop - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 32'd1;
      // mantissa overflowed to 9 bits: renormalise
      if (keep[8]) begin
        keep = keep >> 1;
        expo = expo + 8'd1;
      end
      frac = keep[6:0];
    end
    return {sign, expo, frac};
  endfunction

  // bf16 -> int32 with flush, saturation and NaN flag
  function automatic logic [31:0] bf16_to_int(logic [15:0] b, output logic nan);
    logic        sign;
    logic [7:0]  expo;
    logic [31:0] sig, mag, rem, half;
    int          drop;
    sign = b[15];
    expo = b[14:7];
    sig  = {24'h0, 1'b1, b[6:0]};
    nan  = 1'b0;
    if (expo == 8'd0) return 32'd0;
    if (expo == EXP_MAX) begin
      if (b[6:0] != 7'd0) begin
        nan = 1'b1;
        return I32_MIN;
      end
      return sign ? I32_MIN : I32_MAX;
    end
    if (int'(expo) >= int'(BIAS) + 31) return sign ? I32_MIN : I32_MAX;
    if (int'(expo) >= int'(BIAS) + 7) begin
      mag = sig << (int'(expo) - int'(BIAS) - 7);
    end else begin
      drop = int'(BIAS) + 7 - int'(expo);
      if (drop > 8) begin
        mag = 32'd0;
      end else begin
        mag  = sig >> drop;
        rem  = sig & ((32'd1 << drop) - 32'd1);
        half = 32'd1 << (drop - 1);
        if (rem > half || (rem == half && mag[0])) mag = mag + 32'd1;
      end
    end
    return sign ? (~mag + 32'd1) : mag;
  endfunction

  // fp32 -> bf16: NaN canonicalised, otherwise round the dropped half-word
  function automatic logic [15:0] fp32_to_bf16(logic [31:0] x);
    logic [15:0] upper;
    upper = x[31:16];
    if (x[30:23] == EXP_MAX) begin
      if (x[22:0] != 23'd0) return BF_NAN;
      return x[31] ? BF_NEG_INF : BF_POS_INF;
    end
    // a carry out of the mantissa walks into the exponent; may reach inf
    if (x[15:0] > 16'h8000 || (x[15:0] == 16'h8000 && upper[0])) upper = upper + 16'd1;
    return upper;
  endfunction

  function automatic out_word_t convert_word(in_word_t w);
    out_word_t r;
    logic      nan;
    r = '0;
    case (w.op)
      OP_INT_TO_BF: r.result_bits = {16'h0, int_to_bf16(w.operand)};
      OP_BF_TO_INT: begin
        r.result_bits = bf16_to_int(w.operand[15:0], nan);
        r.nan_seen    = nan;
      end
      OP_FP_TO_BF:  r.result_bits = {16'h0, fp32_to_bf16(w.operand)};
      default:      r.result_bits = {w.operand[15:0], 16'h0};
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Random operands, biased towards the interesting regions of each op
  // ---------------------------------------------------------------------
  function automatic logic [31:0] pick_operand(op_t op);
    logic [31:0] v;
    int          cut;
    v = $urandom;
    case (op)
      OP_INT_TO_BF: begin
        case ($urandom_range(0, 4))
          0: ;                                      // full range
          1: v = v >> $urandom_range(0, 31);        // spread of magnitudes
          2: begin                                  // likely halfway cases
            cut = $urandom_range(1, 23);
            v = ((v >> $urandom_range(0, 8)) & ~((32'd1 << cut) - 32'd1))
                | (32'd1 << (cut - 1));
            if ($urandom_range(0, 1) == 1) v = ~v + 32'd1;
          end
          3: begin
            case ($urandom_range(0, 3))
              0: v = 32'h0000_0000;
              1: v = 32'h8000_0000;
              2: v = 32'h7FFF_FFFF;
              default: v = 32'hFFFF_FFFF;
            endcase
          end
          default: v = {{24{v[31]}}, v[7:0]};       // small, either sign
        endcase
      end
      OP_FP_TO_BF: begin
        case ($urandom_range(0, 3))
          0: ;
          1: v[15:0]  = 16'h8000;                   // exact tie
          2: v[30:23] = EXP_MAX;                    // inf / NaN
          default: v[30:16] = 15'h7F7F;             // round-up overflow region
        endcase
      end
      default: begin
        // bf16 sources: steer the exponent, leave upper junk bits random
        case ($urandom_range(0, 5))
          0: v[14:7] = 8'd0;
          1: v[14:7] = 8'($urandom_range(100, 133));
          2: v[14:7] = 8'($urandom_range(134, 157));
          3: v[14:7] = 8'($urandom_range(158, 254));
          4: v[14:7] = EXP_MAX;
          default: ;
        endcase
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Input side: drive at the falling edge, watch acceptance at the rising
  // ---------------------------------------------------------------------
  task automatic send_word(in_word_t w, out_word_t want);
    int gap;
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    owed_words.push_back('{src: w, want: want});
  endtask

  // hold the input quiet until every owed word has come back
  task automatic drain_owed;
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
  endtask

  // Output side backpressure: random stall bursts
  always @(negedge clk) begin
    if (!out_idle_on || !rst_n) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10);
    end
    out_stall <= (stall_left > 0);
  end

  task automatic report_mismatch(string what, in_word_t src, logic [31:0] got,
                                 logic [31:0] want);
    $display("%0t: %s mismatch (op %0d operand %h): got %h want %h",
             $time, what, src.op, src.operand, got, want);
    mismatch_count++;
  endtask

  // Result scoreboard: each word leaving the block is matched in order
  always @(posedge clk) begin : score_results
    conversion_t owed;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_words.size() == 0) begin
        report_mismatch("unexpected word", '0, out_data.result_bits, 32'h0);
      end else begin
        owed = owed_words.pop_front();
        if (out_data.result_bits !== owed.want.result_bits)
          report_mismatch("result_bits", owed.src, out_data.result_bits,
                          owed.want.result_bits);
        if (out_data.nan_seen !== owed.want.nan_seen)
          report_mismatch("nan_seen", owed.src, 32'(out_data.nan_seen),
                          32'(owed.want.nan_seen));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    in_word_t  w;
    out_word_t want;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      w.op      = directed_rows[i].op;
      w.operand = directed_rows[i].operand;
      if (directed_rows[i].fixed) begin
        want.result_bits = directed_rows[i].want_bits;
        want.nan_seen    = directed_rows[i].want_nan;
      end else begin
        want = convert_word(w);
      end
      send_word(w, want);
    end
    drain_owed();

    // random words; a quiet window mid-run and a quiet tail with no idling
    for (int n = 0; n < 750; n++) begin
      in_idle_on  = !((n >= 250 && n < 320) || n >= 650);
      out_idle_on = in_idle_on;
      if (n == 400) drain_owed();
      w.op      = op_t'($urandom_range(0, 3));
      w.operand = pick_operand(w.op);
      send_word(w, convert_word(w));
    end

    drain_owed();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && owed_words.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #1000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bfc_pkg.sv
hw/rtl/bfc_int_to_bf.sv
hw/rtl/bfc_bf_to_int.sv
hw/rtl/bfc_fp_to_bf.sv
hw/rtl/bf16_format_converter.sv
dv/testbench.sv
